// ===== design/assert_macros.svh =====
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside of reset
`define VDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define VDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/vdpc_pkg.sv =====
package vdpc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SumW    = 64;
  localparam int unsigned SegW    = 21;
  localparam int unsigned ShiftW  = 7;
  localparam int unsigned GroupW  = 7;
  localparam int unsigned CfgIdxW = 1;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgMaxSegIdx    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTargetSegIdx = 1'b1;

  localparam logic [SegW-1:0] MaxSegReset    = 21'd65536;
  localparam logic [SegW-1:0] TargetSegReset = 21'd32768;

  // bit 7 of a byte flags more groups of the same gap
  localparam int unsigned     ContBit    = 7;
  localparam logic [ShiftW-1:0] GroupStep = 7'd7;

  typedef struct packed {
    logic [ByteW-1:0]  byte_value;
    logic              term_start;
    logic [CountW-1:0] term_posting_count;
  } item_t;

  typedef struct packed {
    logic [SumW-1:0] posting;
    logic [SegW-1:0] chunk_length;
    logic            last_in_chunk;
    logic            last_in_term;
  } result_t;

  typedef struct packed {
    logic [SegW-1:0] seg_max;
    logic [SegW-1:0] seg_target;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } dec_out_t;

endpackage

// ===== design/vdpc_chunk_pick.sv =====
module vdpc_chunk_pick (
  input  logic [vdpc_pkg::CountW-1:0] remaining_i,
  input  vdpc_pkg::cfg_t              cfg_i,
  output logic [vdpc_pkg::SegW-1:0]   chunk_len_o
);

  logic [vdpc_pkg::SegW:0]     seg_sum;
  logic [vdpc_pkg::CountW-1:0] len;

  assign seg_sum = {1'b0, cfg_i.seg_target} + {1'b0, cfg_i.seg_max};

  always_comb begin
    priority if (remaining_i <= {{(vdpc_pkg::CountW-vdpc_pkg::SegW){1'b0}},
                                 cfg_i.seg_max}) begin
      len = remaining_i;
    end else if (remaining_i > {{(vdpc_pkg::CountW-vdpc_pkg::SegW-1){1'b0}}, seg_sum}) begin
      len = {{(vdpc_pkg::CountW-vdpc_pkg::SegW){1'b0}}, cfg_i.seg_target};
    end else begin
      len = remaining_i >> 1;
    end
    // an empty chunk still takes one posting
    if (len == '0) begin
      len = {{(vdpc_pkg::CountW-1){1'b0}}, 1'b1};
    end
  end

  assign chunk_len_o = len[vdpc_pkg::SegW-1:0];

endmodule

// ===== design/vdpc_decode.sv =====
`include "assert_macros.svh"

module vdpc_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  vdpc_pkg::item_t     item_i,
  input  vdpc_pkg::cfg_t      cfg_i,
  output vdpc_pkg::dec_out_t  dec_o
);

  logic [vdpc_pkg::SumW-1:0]   sum_q, sum_d, sum_base, grp_shifted;
  logic [vdpc_pkg::ShiftW-1:0] shift_q, shift_d, shift_base;
  logic [vdpc_pkg::CountW-1:0] trem_q, trem_d, trem_base;
  logic [vdpc_pkg::SegW-1:0]   crem_q, crem_d, crem_base, crem_cur;
  logic [vdpc_pkg::SegW-1:0]   csize_q, csize_d, csize_base;
  logic [vdpc_pkg::SegW-1:0]   pick_len;
  logic [vdpc_pkg::GroupW-1:0] grp;

  // a new term clears the decoder before its first byte is decoded
  assign sum_base   = item_i.term_start ? '0 : sum_q;
  assign shift_base = item_i.term_start ? '0 : shift_q;
  assign trem_base  = item_i.term_start ? item_i.term_posting_count : trem_q;
  assign crem_base  = item_i.term_start ? '0 : crem_q;
  assign csize_base = item_i.term_start ? '0 : csize_q;

  assign grp         = item_i.byte_value[vdpc_pkg::GroupW-1:0];
  assign grp_shifted = {{(vdpc_pkg::SumW-vdpc_pkg::GroupW){1'b0}}, grp} << shift_base[5:0];

  vdpc_chunk_pick u_pick (
    .remaining_i (trem_base),
    .cfg_i       (cfg_i),
    .chunk_len_o (pick_len)
  );

  always_comb begin
    sum_d    = sum_base;
    shift_d  = shift_base;
    trem_d   = trem_base;
    crem_d   = crem_base;
    csize_d  = csize_base;
    crem_cur = crem_base;
    dec_o    = '0;
    if (trem_base != '0) begin
      // shift of 64 and up: group lands above the sum and is lost
      if (!shift_base[6]) begin
        sum_d = sum_base + grp_shifted;
      end
      if (item_i.byte_value[vdpc_pkg::ContBit]) begin
        if (!shift_base[6]) begin
          shift_d = shift_base + vdpc_pkg::GroupStep;
        end
      end else begin
        shift_d = '0;
        if (crem_base == '0) begin
          csize_d  = pick_len;
          crem_cur = pick_len;
        end
        crem_d = crem_cur - 1'b1;
        trem_d = trem_base - 1'b1;
        dec_o.valid             = 1'b1;
        dec_o.res.posting       = sum_d;
        dec_o.res.chunk_length  = csize_d;
        dec_o.res.last_in_chunk = (crem_d == '0);
        dec_o.res.last_in_term  = (trem_d == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      shift_q <= '0;
      trem_q  <= '0;
      crem_q  <= '0;
      csize_q <= '0;
    end else if (advance_i) begin
      sum_q   <= sum_d;
      shift_q <= shift_d;
      trem_q  <= trem_d;
      crem_q  <= crem_d;
      csize_q <= csize_d;
    end
  end

  `VDPC_ASSERT(a_term_end_ends_chunk,
      dec_o.valid && dec_o.res.last_in_term |-> dec_o.res.last_in_chunk,
      "term ended inside an open chunk")
  `VDPC_ASSERT(a_chunk_len_nonzero,
      dec_o.valid |-> dec_o.res.chunk_length != '0,
      "posting emitted with empty chunk")
  `VDPC_ASSERT(a_chunk_within_term,
      {{(vdpc_pkg::CountW-vdpc_pkg::SegW){1'b0}}, crem_q} <= trem_q,
      "chunk count exceeds term count")
  `VDPC_ASSERT(a_shift_bound,
      shift_q <= 7'd70,
      "group shift grew past its limit")

endmodule

// ===== design/vbyte_delta_postings_chunker.sv =====
// vbyte_delta_postings_chunker: decodes a term's posting list from
// variable-byte gaps and tags each posting with its chunk information
// - input channel: one compressed byte per request (in_valid_i/in_ready_o);
//   term_start_i marks the first byte of a term and term_posting_count_i
//   is sampled with it
// - output channel: one request per completed gap (out_valid_o/out_ready_i)
//   carrying the absolute posting, chunk length and last flags
// - config channel: cfg_index_i selects max (0) or target (1) segment size;
//   always ready, write only while the block is idle
// - path: a byte goes from the input register through decode into the
//   output register, which drives the outputs (two register stages)
// - throughput: one byte per cycle while the output is not stalled, set
//   by the single decode stage between the input and output registers
// - stall: while the output register is full and not taken, the decode
//   stage holds; the input register takes one more request only if empty
// - reset: decoder state is zero, segment sizes return to 65536 / 32768,
//   both channel registers empty; no bytes are decoded until a term starts
`include "assert_macros.svh"

module vbyte_delta_postings_chunker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vdpc_pkg::ByteW-1:0]    byte_value_i,
  input  logic                          term_start_i,
  input  logic [vdpc_pkg::CountW-1:0]   term_posting_count_i,
  // posting requests
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vdpc_pkg::SumW-1:0]     posting_o,
  output logic [vdpc_pkg::SegW-1:0]     chunk_length_o,
  output logic                          last_in_chunk_o,
  output logic                          last_in_term_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vdpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vdpc_pkg::SegW-1:0]     cfg_data_i
);

  vdpc_pkg::item_t    item_q;
  logic               in_valid_q;
  vdpc_pkg::result_t  res_q;
  logic               out_valid_q;
  vdpc_pkg::cfg_t     cfg_q;
  vdpc_pkg::dec_out_t dec;
  logic               advance;

  // decode moves ahead when the output slot is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.byte_value         <= byte_value_i;
      item_q.term_start         <= term_start_i;
      item_q.term_posting_count <= term_posting_count_i;
    end
  end

  // segment size registers, picked up when the next chunk opens
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seg_max    <= vdpc_pkg::MaxSegReset;
      cfg_q.seg_target <= vdpc_pkg::TargetSegReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vdpc_pkg::CfgMaxSegIdx:    cfg_q.seg_max    <= cfg_data_i;
        vdpc_pkg::CfgTargetSegIdx: cfg_q.seg_target <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vdpc_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .dec_o     (dec)
  );

  // output register; continuation bytes leave it untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && dec.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && dec.valid) begin
      res_q <= dec.res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign posting_o       = res_q.posting;
  assign chunk_length_o  = res_q.chunk_length;
  assign last_in_chunk_o = res_q.last_in_chunk;
  assign last_in_term_o  = res_q.last_in_term;

  `VDPC_ASSERT_ALWAYS(a_ready_low_means_full,
      !in_ready_o |-> in_valid_q,
      "input stalled with an empty input register")
  `VDPC_ASSERT(a_no_overwrite,
      out_valid_q && !out_ready_i |-> !(advance && dec.valid),
      "pending posting overwritten")

endmodule
